/* rtl/phd_pkg.sv */
`default_nettype none
package phd_pkg;

   localparam int unsigned RegWidth   = 5;
   localparam int unsigned OpWidth    = 7;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CauseWidth = 3;

   localparam int unsigned ReqDataWidth = 128;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [OpWidth-1:0] OP_FP_R     = 7'h53;
   localparam logic [OpWidth-1:0] OP_FMADD    = 7'h43;
   localparam logic [OpWidth-1:0] OP_FMSUB    = 7'h47;
   localparam logic [OpWidth-1:0] OP_FNMSUB   = 7'h4B;
   localparam logic [OpWidth-1:0] OP_FNMADD   = 7'h4F;
   localparam logic [OpWidth-1:0] OP_FP_LOAD  = 7'h07;
   localparam logic [OpWidth-1:0] OP_GPR_LOAD = 7'h03;
   localparam logic [OpWidth-1:0] OP_FP_STORE = 7'h27;
   localparam logic [OpWidth-1:0] OP_STORE    = 7'h23;
   localparam logic [OpWidth-1:0] OP_REG      = 7'h33;
   localparam logic [OpWidth-1:0] OP_REG32    = 7'h3B;
   localparam logic [OpWidth-1:0] OP_IMM      = 7'h13;
   localparam logic [OpWidth-1:0] OP_IMM32    = 7'h1B;
   localparam logic [OpWidth-1:0] OP_BRANCH   = 7'h63;
   localparam logic [OpWidth-1:0] OP_JALR     = 7'h67;

   localparam logic [6:0] F7_FCMP_S    = 7'h50;
   localparam logic [6:0] F7_FCMP_D    = 7'h51;
   localparam logic [6:0] F7_FCVT_W_S  = 7'h60;
   localparam logic [6:0] F7_FCVT_W_D  = 7'h61;
   localparam logic [6:0] F7_FMV_X_W   = 7'h70;
   localparam logic [6:0] F7_FMV_X_D   = 7'h71;
   localparam logic [6:0] F7_FCVT_S_W  = 7'h68;
   localparam logic [6:0] F7_FCVT_D_W  = 7'h69;
   localparam logic [6:0] F7_FMV_W_X   = 7'h78;
   localparam logic [6:0] F7_FMV_D_X   = 7'h79;

   localparam logic [CauseWidth-1:0] CAUSE_NONE     = 3'd0;
   localparam logic [CauseWidth-1:0] CAUSE_EXE_LOAD = 3'd1;
   localparam logic [CauseWidth-1:0] CAUSE_MEM_LOAD = 3'd2;
   localparam logic [CauseWidth-1:0] CAUSE_WB_LOAD  = 3'd3;
   localparam logic [CauseWidth-1:0] CAUSE_MEM_RAW  = 3'd4;
   localparam logic [CauseWidth-1:0] CAUSE_WB_RAW   = 3'd5;

   // highest field first, so fetch_valid lands in bit 0
   typedef struct packed {
      logic [WordWidth-1:0]   wb_word;
      logic [RegWidth-1:0]    wb_dest;
      logic [2:0]             wb_flags;
      logic [WordWidth-1:0]   mem_word;
      logic [RegWidth-1:0]    mem_dest;
      logic [2:0]             mem_flags;
      logic [OpWidth-1:0]     exe_opcode;
      logic [RegWidth-1:0]    exe_dest;
      logic [1:0]             exe_flags;
      logic [WordWidth-1:0]   fetch_word;
      logic                   fetch_valid;
   } snapshot_type;

   typedef struct packed {
      logic                  stall_res;
      logic [CauseWidth-1:0] cause;
   } verdict_type;

endpackage
`default_nettype wire

/* rtl/phd_decide.sv */
`default_nettype none
module phd_decide
   import phd_pkg::*;
(
   input  wire snapshot_type snap,
   input  wire logic         forwarding_on,
   output verdict_type       verdict
);

   logic                g1, g2, f1, f2, f3;
   logic [RegWidth-1:0] r1, r2, r3;
   logic [OpWidth-1:0]  fop, mop, wop;
   logic [6:0]          ff7;
   logic                fetch_gpr_in;
   logic                exe_load_hit, mem_load_hit, wb_load_hit;
   logic                mem_raw_hit, wb_raw_hit;

   function automatic logic is_fmadd(input logic [OpWidth-1:0] op);
      return op == OP_FMADD || op == OP_FMSUB || op == OP_FNMSUB || op == OP_FNMADD;
   endfunction

   function automatic logic writes_gpr_from_fp(input logic [6:0] f);
      return f == F7_FCMP_S || f == F7_FCMP_D || f == F7_FCVT_W_S || f == F7_FCVT_W_D ||
             f == F7_FMV_X_W || f == F7_FMV_X_D;
   endfunction

   function automatic logic needs_fp(input logic a1, input logic a2, input logic a3,
                                     input logic [RegWidth-1:0] s1,
                                     input logic [RegWidth-1:0] s2,
                                     input logic [RegWidth-1:0] s3,
                                     input logic [RegWidth-1:0] rd);
      return (a1 && rd == s1) || (a2 && rd == s2) || (a3 && rd == s3);
   endfunction

   function automatic logic needs_gpr(input logic a1, input logic a2,
                                      input logic [RegWidth-1:0] s1,
                                      input logic [RegWidth-1:0] s2,
                                      input logic [RegWidth-1:0] rd);
      return (a1 && rd == s1) || (a2 && rd == s2);
   endfunction

   function automatic logic load_hits(input logic a_g1, input logic a_g2,
                                      input logic a_f1, input logic a_f2,
                                      input logic a_f3,
                                      input logic [RegWidth-1:0] s1,
                                      input logic [RegWidth-1:0] s2,
                                      input logic [RegWidth-1:0] s3,
                                      input logic [OpWidth-1:0] op,
                                      input logic [RegWidth-1:0] rd);
      logic hit;
      hit = 1'b0;
      if (op == OP_FP_LOAD) begin
         hit = needs_fp(a_f1, a_f2, a_f3, s1, s2, s3, rd);
      end else if (op == OP_GPR_LOAD) begin
         hit = (rd != '0) && needs_gpr(a_g1, a_g2, s1, s2, rd);
      end
      return hit;
   endfunction

   function automatic logic writer_hits(input logic a_g1, input logic a_g2,
                                        input logic a_f1, input logic a_f2,
                                        input logic a_f3,
                                        input logic [RegWidth-1:0] s1,
                                        input logic [RegWidth-1:0] s2,
                                        input logic [RegWidth-1:0] s3,
                                        input logic [WordWidth-1:0] w,
                                        input logic [RegWidth-1:0] rd);
      logic fp;
      if (w[6:0] == OP_FP_R) begin
         fp = !writes_gpr_from_fp(w[31:25]);
      end else begin
         fp = is_fmadd(w[6:0]) || w[6:0] == OP_FP_LOAD;
      end
      return fp ? needs_fp(a_f1, a_f2, a_f3, s1, s2, s3, rd)
                : needs_gpr(a_g1, a_g2, s1, s2, rd);
   endfunction

   assign fop = snap.fetch_word[6:0];
   assign ff7 = snap.fetch_word[31:25];
   assign mop = snap.mem_word[6:0];
   assign wop = snap.wb_word[6:0];
   assign r1  = snap.fetch_word[19:15];
   assign r2  = snap.fetch_word[24:20];
   assign r3  = snap.fetch_word[31:27];

   assign fetch_gpr_in = ff7 == F7_FCVT_S_W || ff7 == F7_FCVT_D_W ||
                         ff7 == F7_FMV_W_X || ff7 == F7_FMV_D_X;

   // source usage of the consumer
   always_comb begin
      g1 = 1'b0;
      g2 = 1'b0;
      f1 = 1'b0;
      f2 = 1'b0;
      f3 = 1'b0;
      case (fop)
         OP_REG, OP_REG32, OP_STORE, OP_BRANCH: begin
            g1 = 1'b1;
            g2 = 1'b1;
         end
         OP_IMM, OP_IMM32, OP_GPR_LOAD, OP_JALR, OP_FP_LOAD: begin
            g1 = 1'b1;
         end
         OP_FP_R: begin
            g1 = fetch_gpr_in;
            f1 = !fetch_gpr_in;
            f2 = !fetch_gpr_in;
         end
         OP_FMADD, OP_FMSUB, OP_FNMSUB, OP_FNMADD: begin
            f1 = 1'b1;
            f2 = 1'b1;
            f3 = 1'b1;
         end
         OP_FP_STORE: begin
            g1 = 1'b1;
            f2 = 1'b1;
         end
         default: begin
            g1 = 1'b0;
         end
      endcase
   end

   assign exe_load_hit = snap.exe_flags == 2'b11 &&
      load_hits(g1, g2, f1, f2, f3, r1, r2, r3, snap.exe_opcode, snap.exe_dest);
   assign mem_load_hit = snap.mem_flags[0] && snap.mem_flags[1] &&
      load_hits(g1, g2, f1, f2, f3, r1, r2, r3, mop, snap.mem_dest);
   assign wb_load_hit = !forwarding_on && snap.wb_flags[0] && snap.wb_flags[1] &&
      load_hits(g1, g2, f1, f2, f3, r1, r2, r3, wop, snap.wb_dest);
   assign mem_raw_hit = !forwarding_on && snap.mem_flags[0] && snap.mem_flags[2] &&
      !snap.mem_flags[1] && snap.mem_dest != '0 &&
      writer_hits(g1, g2, f1, f2, f3, r1, r2, r3, snap.mem_word, snap.mem_dest);
   assign wb_raw_hit = !forwarding_on && snap.wb_flags[0] && snap.wb_flags[2] &&
      snap.wb_dest != '0 &&
      writer_hits(g1, g2, f1, f2, f3, r1, r2, r3, snap.wb_word, snap.wb_dest);

   always_comb begin
      verdict.cause = CAUSE_NONE;
      if (snap.fetch_valid) begin
         if (exe_load_hit) begin
            verdict.cause = CAUSE_EXE_LOAD;
         end else if (mem_load_hit) begin
            verdict.cause = CAUSE_MEM_LOAD;
         end else if (wb_load_hit) begin
            verdict.cause = CAUSE_WB_LOAD;
         end else if (mem_raw_hit) begin
            verdict.cause = CAUSE_MEM_RAW;
         end else if (wb_raw_hit) begin
            verdict.cause = CAUSE_WB_RAW;
         end
      end
      verdict.stall_res = verdict.cause != CAUSE_NONE;
   end

endmodule
`default_nettype wire

/* rtl/pipeline_data_hazard_detect.sv */
// Load-use and RAW hazard check for a five-stage RV64 F/D pipeline. Each transaction on the
// req_ channel is one snapshot of the IF/ID, ID/EX, EX/MEM and MEM/WB stage fields; the rsp_
// channel returns one stall decision with its cause code per snapshot, in order. A snapshot
// is registered, decided by one level of compare logic and registered again, and one
// transaction is taken every cycle while the result side keeps up. csr_wr_en loads
// forwarding_on (reset 1) from csr_wr_data; with it cleared, MEM/WB loads and non-load
// writers in EX/MEM and MEM/WB also stall. Write it only while no transaction is in flight.
`default_nettype none
module pipeline_data_hazard_detect
   import phd_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic                    csr_wr_data,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // fetch_valid, fetch_word, exe_flags, exe_dest, exe_opcode, mem_flags, mem_dest,
   // mem_word, wb_flags, wb_dest, wb_word, zero pad
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // stall_res, cause, zero pad
   output logic [RspDataWidth-1:0]      rsp_tdata
);

   logic         fwd_ff;
   logic         in_valid_ff;
   snapshot_type in_snap_ff;
   logic         out_valid_ff;
   verdict_type  out_verdict_ff;
   verdict_type  verdict_in;
   logic         out_ready;
   logic         in_ready;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b1;
      end else if (csr_wr_en) begin
         fwd_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_snap_ff <= snapshot_type'(req_tdata[$bits(snapshot_type)-1:0]);
      end
   end

   phd_decide u_decide (
      .snap          (in_snap_ff),
      .forwarding_on (fwd_ff),
      .verdict       (verdict_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid_ff) begin
         out_verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-CauseWidth-1){1'b0}},
                        out_verdict_ff.cause, out_verdict_ff.stall_res};

endmodule
`default_nettype wire

/* rtl/phd_check.sv */
`default_nettype none
module phd_check
   import phd_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_tvalid,
   input wire logic                    req_tready,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RspDataWidth-1:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[CauseWidth:1] != CAUSE_NONE))
      else $error("stall flag disagrees with cause");

   a_cause_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CauseWidth:1] <= CAUSE_WB_RAW &&
                      rsp_tdata[RspDataWidth-1:CauseWidth+1] == '0))
      else $error("cause out of range or pad bits set");

   a_no_result_from_nothing: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(req_tvalid && req_tready) && !$past(rsp_tvalid)
         && !$past(rsp_tvalid, 2) && !$past(req_tvalid && req_tready, 2)
         |-> !rsp_tvalid)
      else $error("result with no request in flight");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind pipeline_data_hazard_detect phd_check u_phd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* test/pipeline_data_hazard_detect_tb.sv */
`timescale 1ns / 1ps
module pipeline_data_hazard_detect_tb;
   import phd_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic                 pad;
      logic [WordWidth-1:0] wb_word;
      logic [RegWidth-1:0]  wb_dest;
      logic [2:0]           wb_flags;
      logic [WordWidth-1:0] mem_word;
      logic [RegWidth-1:0]  mem_dest;
      logic [2:0]           mem_flags;
      logic [OpWidth-1:0]   exe_opcode;
      logic [RegWidth-1:0]  exe_dest;
      logic [1:0]           exe_flags;
      logic [WordWidth-1:0] fetch_word;
      logic                 fetch_valid;
   } stage_snapshot_t;

   typedef struct packed {
      logic                g1, g2, f1, f2, f3;
      logic [RegWidth-1:0] r1, r2, r3;
   } operand_use_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   logic fwd_on = 1'b1;
   stage_snapshot_t snapshot_q[$];
   verdict_type verdict_q[$];
   int mismatch_cnt = 0;
   int gap_left = 0;
   int burst_left = 8;
   int stall_left = 0;
   int mode_left = 0;
   int ready_mode = 0;
   int idle_cycles = 0;

   pipeline_data_hazard_detect dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic fmadd_op(logic [OpWidth-1:0] op);
      return op inside {OP_FMADD, OP_FMSUB, OP_FNMSUB, OP_FNMADD};
   endfunction

   function automatic logic needs_reg(operand_use_t u, logic fp, logic [RegWidth-1:0] rd);
      if (fp) begin
         return (u.f1 && rd == u.r1) || (u.f2 && rd == u.r2) || (u.f3 && rd == u.r3);
      end
      return (u.g1 && rd == u.r1) || (u.g2 && rd == u.r2);
   endfunction

   function automatic logic load_hit(operand_use_t u, logic [OpWidth-1:0] op,
                                     logic [RegWidth-1:0] rd);
      if (op == OP_FP_LOAD) begin
         return needs_reg(u, 1'b1, rd);
      end
      if (op == OP_GPR_LOAD) begin
         return rd != '0 && needs_reg(u, 1'b0, rd);
      end
      return 1'b0;
   endfunction

   function automatic logic writer_hit(operand_use_t u, logic [WordWidth-1:0] w,
                                       logic [RegWidth-1:0] rd);
      logic fp;
      if (w[6:0] == OP_FP_R) begin
         fp = !(w[31:25] inside {F7_FCMP_S, F7_FCMP_D, F7_FCVT_W_S, F7_FCVT_W_D,
                                 F7_FMV_X_W, F7_FMV_X_D});
      end else begin
         fp = fmadd_op(w[6:0]) || w[6:0] == OP_FP_LOAD;
      end
      return needs_reg(u, fp, rd);
   endfunction

   function automatic verdict_type hazard_verdict(stage_snapshot_t s, logic fwd);
      operand_use_t u;
      logic [OpWidth-1:0] op;
      logic [6:0] f7;
      verdict_type v;
      op = s.fetch_word[6:0];
      f7 = s.fetch_word[31:25];
      u = '0;
      u.r1 = s.fetch_word[19:15];
      u.r2 = s.fetch_word[24:20];
      u.r3 = s.fetch_word[31:27];
      v.cause = CAUSE_NONE;
      if (op inside {OP_REG, OP_REG32, OP_STORE, OP_BRANCH}) begin
         u.g1 = 1'b1;
         u.g2 = 1'b1;
      end else if (op inside {OP_IMM, OP_IMM32, OP_GPR_LOAD, OP_JALR, OP_FP_LOAD}) begin
         u.g1 = 1'b1;
      end else if (op == OP_FP_R) begin
         if (f7 inside {F7_FCVT_S_W, F7_FCVT_D_W, F7_FMV_W_X, F7_FMV_D_X}) begin
            u.g1 = 1'b1;
         end else begin
            u.f1 = 1'b1;
            u.f2 = 1'b1;
         end
      end else if (fmadd_op(op)) begin
         u.f1 = 1'b1;
         u.f2 = 1'b1;
         u.f3 = 1'b1;
      end else if (op == OP_FP_STORE) begin
         u.g1 = 1'b1;
         u.f2 = 1'b1;
      end
      if (s.fetch_valid) begin
         if (s.exe_flags == 2'b11 && load_hit(u, s.exe_opcode, s.exe_dest)) begin
            v.cause = CAUSE_EXE_LOAD;
         end else if (s.mem_flags[0] && s.mem_flags[1] &&
                      load_hit(u, s.mem_word[6:0], s.mem_dest)) begin
            v.cause = CAUSE_MEM_LOAD;
         end else if (!fwd && s.wb_flags[0] && s.wb_flags[1] &&
                      load_hit(u, s.wb_word[6:0], s.wb_dest)) begin
            v.cause = CAUSE_WB_LOAD;
         end else if (!fwd && s.mem_flags[0] && s.mem_flags[2] && !s.mem_flags[1] &&
                      s.mem_dest != '0 && writer_hit(u, s.mem_word, s.mem_dest)) begin
            v.cause = CAUSE_MEM_RAW;
         end else if (!fwd && s.wb_flags[0] && s.wb_flags[2] && s.wb_dest != '0 &&
                      writer_hit(u, s.wb_word, s.wb_dest)) begin
            v.cause = CAUSE_WB_RAW;
         end
      end
      v.stall_res = v.cause != CAUSE_NONE;
      return v;
   endfunction

   function automatic logic [WordWidth-1:0] mk_word(logic [OpWidth-1:0] op, logic [6:0] f7,
                                                    logic [4:0] rs1, logic [4:0] rs2);
      return {f7, rs2, rs1, 3'b000, 5'd0, op};
   endfunction

   function automatic logic [OpWidth-1:0] pick_opcode();
      case ($urandom_range(0, 17))
         0: return OP_FP_R;
         1: return OP_FMADD;
         2: return OP_FMSUB;
         3: return OP_FNMSUB;
         4: return OP_FNMADD;
         5: return OP_FP_LOAD;
         6: return OP_GPR_LOAD;
         7: return OP_FP_STORE;
         8: return OP_STORE;
         9: return OP_REG;
         10: return OP_REG32;
         11: return OP_IMM;
         12: return OP_IMM32;
         13: return OP_BRANCH;
         14: return OP_JALR;
         default: return OpWidth'($urandom);
      endcase
   endfunction

   function automatic logic [6:0] pick_funct7();
      case ($urandom_range(0, 13))
         0: return F7_FCMP_S;
         1: return F7_FCMP_D;
         2: return F7_FCVT_W_S;
         3: return F7_FCVT_W_D;
         4: return F7_FMV_X_W;
         5: return F7_FMV_X_D;
         6: return F7_FCVT_S_W;
         7: return F7_FCVT_D_W;
         8: return F7_FMV_W_X;
         9: return F7_FMV_D_X;
         default: return 7'($urandom);
      endcase
   endfunction

   // small pool so that sources and destinations collide often
   function automatic logic [RegWidth-1:0] pick_reg();
      if ($urandom_range(0, 9) < 7) begin
         return RegWidth'($urandom_range(0, 3));
      end
      return RegWidth'($urandom);
   endfunction

   function automatic logic [WordWidth-1:0] rand_word();
      logic [WordWidth-1:0] w;
      w = $urandom;
      w[6:0] = pick_opcode();
      w[19:15] = pick_reg();
      w[24:20] = pick_reg();
      w[31:27] = pick_reg();
      if (w[6:0] == OP_FP_R && $urandom_range(0, 3) != 0) begin
         w[31:25] = pick_funct7();
      end
      return w;
   endfunction

   task automatic add_item(input logic fv, input logic [31:0] fw, input logic [1:0] exf,
                           input logic [4:0] exd, input logic [6:0] exo,
                           input logic [2:0] mf, input logic [4:0] md, input logic [31:0] mw,
                           input logic [2:0] wf, input logic [4:0] wd, input logic [31:0] ww);
      stage_snapshot_t s;
      s = '0;
      s.fetch_valid = fv;
      s.fetch_word = fw;
      s.exe_flags = exf;
      s.exe_dest = exd;
      s.exe_opcode = exo;
      s.mem_flags = mf;
      s.mem_dest = md;
      s.mem_word = mw;
      s.wb_flags = wf;
      s.wb_dest = wd;
      s.wb_word = ww;
      snapshot_q.push_back(s);
   endtask

   task automatic add_random(input int count);
      stage_snapshot_t s;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            s = stage_snapshot_t'({$urandom, $urandom, $urandom, $urandom});
            s.pad = 1'b0;
            snapshot_q.push_back(s);
         end else begin
            add_item($urandom_range(0, 9) != 0, rand_word(),
                     ($urandom_range(0, 2) == 0) ? 2'($urandom) : 2'b11, pick_reg(),
                     ($urandom_range(0, 1) == 0) ? pick_opcode() :
                        (($urandom_range(0, 1) == 0) ? OP_GPR_LOAD : OP_FP_LOAD),
                     3'($urandom), pick_reg(), rand_word(),
                     3'($urandom), pick_reg(), rand_word());
         end
      end
   endtask

   // sample on the falling edge so the driver's updates have settled
   task automatic wait_idle();
      while (snapshot_q.size() != 0 || req_tvalid || verdict_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_forwarding(input logic value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      fwd_on <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : drive_req
      logic nxt_valid;
      stage_snapshot_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(hazard_verdict(stage_snapshot_t'(req_tdata), fwd_on));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (snapshot_q.size() != 0) begin
               nxt = snapshot_q.pop_front();
               req_tdata <= nxt;
               nxt_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 32);
                  case ($urandom_range(0, 3))
                     0: gap_left = 0;
                     1: gap_left = $urandom_range(1, 2);
                     2: gap_left = $urandom_range(3, 8);
                     default: gap_left = $urandom_range(10, 24);
                  endcase
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   always @(posedge clock) begin : check_rsp
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10) begin
                  $display("unexpected result stall_res=%0d cause=%0d",
                           rsp_tdata[0], rsp_tdata[3:1]);
               end
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want.stall_res || rsp_tdata[3:1] !== want.cause) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10) begin
                     $display("mismatch: expected stall_res=%0d cause=%0d, got %0d %0d",
                              want.stall_res, want.cause, rsp_tdata[0], rsp_tdata[3:1]);
                  end
               end
            end
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (ready_mode == 1 && $urandom_range(0, 9) < 3) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else if (ready_mode == 2 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(4, 19);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_forwarding(1'b1);
      add_item(0, '0, 0, 0, '0, 0, 0, '0, 0, 0, '0);
      add_item(1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
      // invalid consumer with a load hit
      add_item(0, mk_word(OP_REG, 0, 5, 6), 2'b11, 5, OP_GPR_LOAD, 0, 0, '0, 0, 0, '0);
      add_item(1, mk_word(OP_REG, 0, 5, 6), 2'b11, 6, OP_GPR_LOAD, 0, 0, '0, 0, 0, '0);
      // integer load to x0
      add_item(1, mk_word(OP_IMM, 0, 0, 0), 2'b11, 0, OP_GPR_LOAD, 0, 0, '0, 0, 0, '0);
      // fp load to f0
      add_item(1, mk_word(OP_FP_R, 0, 0, 3), 2'b11, 0, OP_FP_LOAD, 0, 0, '0, 0, 0, '0);
      // memory read with a non-load opcode
      add_item(1, mk_word(OP_REG, 0, 5, 6), 2'b11, 5, OP_REG, 0, 0, '0, 0, 0, '0);
      add_item(1, mk_word(OP_FMADD, {5'd9, 2'b00}, 1, 2), 0, 0, '0,
               3'b011, 9, mk_word(OP_FP_LOAD, 0, 0, 0), 0, 0, '0);
      add_item(1, mk_word(OP_BRANCH, 0, 4, 4), 2'b01, 4, OP_GPR_LOAD,
               3'b010, 4, mk_word(OP_GPR_LOAD, 0, 0, 0), 0, 0, '0);
      // int-to-fp consumer reads a gpr
      add_item(1, mk_word(OP_FP_R, F7_FCVT_S_W, 8, 0), 2'b11, 8, OP_GPR_LOAD,
               0, 0, '0, 0, 0, '0);
      add_item(1, mk_word(OP_FP_R, F7_FCVT_S_W, 8, 0), 2'b11, 8, OP_FP_LOAD,
               0, 0, '0, 0, 0, '0);
      add_item(1, mk_word(OP_FP_STORE, 0, 10, 11), 0, 0, '0,
               3'b011, 11, mk_word(OP_FP_LOAD, 0, 0, 0), 0, 0, '0);
      add_item(1, mk_word(OP_REG, 0, 12, 0), 0, 0, '0, 0, 0, '0,
               3'b011, 12, mk_word(OP_GPR_LOAD, 0, 0, 0));
      add_random(130);
      wait_idle();

      write_forwarding(1'b0);
      add_item(1, mk_word(OP_REG, 0, 12, 0), 0, 0, '0, 0, 0, '0,
               3'b011, 12, mk_word(OP_GPR_LOAD, 0, 0, 0));
      add_item(1, mk_word(OP_REG32, 0, 1, 7), 0, 0, '0,
               3'b101, 7, mk_word(OP_REG, 0, 2, 3), 0, 0, '0);
      add_item(1, mk_word(OP_REG32, 0, 1, 7), 0, 0, '0,
               3'b111, 7, mk_word(OP_REG, 0, 2, 3), 0, 0, '0);
      add_item(1, mk_word(OP_JALR, 0, 13, 0), 0, 0, '0, 0, 0, '0,
               3'b101, 13, mk_word(OP_IMM, 0, 1, 0));
      // writer with destination zero
      add_item(1, mk_word(OP_FP_R, 0, 0, 0), 0, 0, '0,
               3'b101, 0, mk_word(OP_FP_R, 0, 1, 2), 3'b101, 0, mk_word(OP_FMADD, 0, 1, 2));
      // fmadd producer stays an fp writer
      add_item(1, mk_word(OP_FP_R, 0, 14, 1), 0, 0, '0,
               3'b101, 14, mk_word(OP_FMADD, F7_FCMP_S, 1, 2), 0, 0, '0);
      add_item(1, mk_word(OP_IMM, 0, 15, 0), 0, 0, '0, 0, 0, '0,
               3'b101, 15, mk_word(OP_FP_R, F7_FCMP_D, 1, 2));
      add_item(1, mk_word(OP_REG, 0, 16, 17), 2'b11, 16, OP_GPR_LOAD,
               3'b101, 17, mk_word(OP_REG, 0, 1, 2), 3'b011, 16, mk_word(OP_GPR_LOAD, 0, 0, 0));
      // unknown consumer opcode
      add_item(1, mk_word(7'h7F, 0, 16, 17), 2'b11, 16, OP_GPR_LOAD,
               3'b101, 17, mk_word(OP_REG, 0, 1, 2), 3'b011, 16, mk_word(OP_GPR_LOAD, 0, 0, 0));
      add_item(1, mk_word(OP_FP_R, F7_FMV_D_X, 18, 0), 0, 0, '0,
               3'b101, 18, mk_word(OP_FP_R, F7_FMV_X_D, 1, 0), 0, 0, '0);
      add_random(140);
      wait_idle();

      write_forwarding(1'b1);
      add_random(130);
      wait_idle();

      write_forwarding(1'b0);
      add_random(130);
      wait_idle();

      if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
